// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== hdl/tcst_pkg.sv =====
// ----------------------------------------------------------------------------
// tcst_pkg
// Types, codes and constant tables of the TCP connection state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcst_pkg;

  localparam int unsigned CONNECTIONS = 256;
  localparam int unsigned IDX_W       = $clog2(CONNECTIONS);
  localparam int unsigned TPS_W       = 11;
  localparam int unsigned SECS_W      = 19;
  localparam int unsigned TMO_W       = 29;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned HDR_W       = 4;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 40;

  localparam logic [TPS_W-1:0] TPS_RESET = 11'd100;
  localparam logic [TPS_W-1:0] TPS_MIN   = 11'd1;
  localparam logic [TPS_W-1:0] TPS_MAX   = 11'd1024;

  typedef enum logic [3:0] {
    ST_NONE        = 4'd0,
    ST_ESTABLISHED = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RECV    = 4'd3,
    ST_FIN_WAIT    = 4'd4,
    ST_TIME_WAIT   = 4'd5,
    ST_CLOSE       = 4'd6,
    ST_CLOSE_WAIT  = 4'd7,
    ST_LAST_ACK    = 4'd8,
    ST_LISTEN      = 4'd9
  } tcp_state_e;

  localparam logic [3:0] ST_LAST = ST_LISTEN;

  typedef enum logic [2:0] {
    CLS_SYN  = 3'd0,
    CLS_FIN  = 3'd1,
    CLS_ACK  = 3'd2,
    CLS_RST  = 3'd3,
    CLS_NONE = 3'd4
  } flag_cls_e;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT  = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_DELETE  = 2'd2
  } verdict_e;

  typedef enum logic {
    ACT_OPEN   = 1'b0,
    ACT_PACKET = 1'b1
  } action_e;

  // Stored entry: reply mark above the 4-bit state
  typedef struct packed {
    logic       mark;
    logic [3:0] st;
  } entry_t;

  // [direction][flag class][state]
  localparam logic [3:0] NEXT_TAB [2][4][10] = '{
    '{
      '{ST_SYN_SENT, ST_ESTABLISHED, ST_SYN_SENT, ST_ESTABLISHED, ST_SYN_SENT,
        ST_SYN_SENT, ST_SYN_SENT, ST_SYN_SENT, ST_SYN_SENT, ST_LISTEN},
      '{ST_TIME_WAIT, ST_FIN_WAIT, ST_SYN_SENT, ST_TIME_WAIT, ST_FIN_WAIT,
        ST_TIME_WAIT, ST_CLOSE, ST_TIME_WAIT, ST_LAST_ACK, ST_LISTEN},
      '{ST_ESTABLISHED, ST_ESTABLISHED, ST_SYN_SENT, ST_SYN_RECV, ST_FIN_WAIT,
        ST_TIME_WAIT, ST_CLOSE, ST_CLOSE_WAIT, ST_LAST_ACK, ST_ESTABLISHED},
      '{ST_CLOSE, ST_CLOSE, ST_SYN_SENT, ST_CLOSE, ST_CLOSE,
        ST_TIME_WAIT, ST_CLOSE, ST_CLOSE, ST_CLOSE, ST_CLOSE}
    },
    '{
      '{ST_SYN_RECV, ST_ESTABLISHED, ST_ESTABLISHED, ST_SYN_RECV, ST_SYN_RECV,
        ST_SYN_RECV, ST_SYN_RECV, ST_SYN_RECV, ST_SYN_RECV, ST_SYN_RECV},
      '{ST_CLOSE, ST_CLOSE_WAIT, ST_SYN_SENT, ST_TIME_WAIT, ST_TIME_WAIT,
        ST_TIME_WAIT, ST_CLOSE, ST_CLOSE_WAIT, ST_LAST_ACK, ST_LISTEN},
      '{ST_CLOSE, ST_ESTABLISHED, ST_SYN_SENT, ST_SYN_RECV, ST_FIN_WAIT,
        ST_TIME_WAIT, ST_CLOSE, ST_CLOSE_WAIT, ST_CLOSE, ST_LISTEN},
      '{ST_CLOSE, ST_CLOSE, ST_CLOSE, ST_SYN_RECV, ST_CLOSE,
        ST_CLOSE, ST_CLOSE, ST_CLOSE, ST_LAST_ACK, ST_LISTEN}
    }
  };

  function automatic logic [3:0] next_state_f(logic dir, logic [1:0] cls, logic [3:0] st);
    logic [3:0] s;
    s = (st > ST_LAST) ? ST_NONE : st;
    return NEXT_TAB[dir][cls][s];
  endfunction

  function automatic logic [SECS_W-1:0] state_seconds_f(logic [3:0] st);
    logic [SECS_W-1:0] secs;
    case (st)
      ST_NONE:        secs = 19'd1800;
      ST_ESTABLISHED: secs = 19'd432000;
      ST_SYN_SENT:    secs = 19'd120;
      ST_SYN_RECV:    secs = 19'd60;
      ST_FIN_WAIT:    secs = 19'd120;
      ST_TIME_WAIT:   secs = 19'd120;
      ST_CLOSE:       secs = 19'd10;
      ST_CLOSE_WAIT:  secs = 19'd60;
      ST_LAST_ACK:    secs = 19'd30;
      ST_LISTEN:      secs = 19'd120;
      default:        secs = '0;
    endcase
    return secs;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcp_connection_state_tracker.sv =====
// Pipeline: an accepted request passes the stage 1 register and registered table read, then
//   the result register; one request per cycle sustained unless the result stream stalls,
//   set by one table read-modify-write per item, with same-entry forwarding back to back.
// Reset: asynchronous, active low; all connection entries read as none state with the reply
//   mark clear (per-entry valid flops), ticks_per_second returns to 100.
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker
// Tracks TCP state and reply mark for 256 connections; one verdict per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcp_connection_state_tracker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write: ticks_per_second
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tcst_pkg::TPS_W-1:0]         cfg_data_i,
  // request stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata, low bit up: conn_index[8], direction[1], flag_rst[1], flag_syn[1],
  //   flag_fin[1], flag_ack[1], packet_length[16], ip_header_words[4],
  //   tcp_header_words[4], zero pad[3]
  input  wire logic [tcst_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: action[1]
  input  wire logic                               s_axis_tuser_i,
  // result stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata, low bit up: verdict[2], next_state[4], reply_mark[1],
  //   timeout_ticks[29], zero pad[4]
  output logic [tcst_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned IW = tcst_pkg::IDX_W;

  // --------------------------------------------------------------------------
  // Configuration: clamp to 1..1024 so the timeout always fits in 29 bits
  // --------------------------------------------------------------------------
  logic [tcst_pkg::TPS_W-1:0] tps_q, tps_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    tps_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      tps_d = tcst_pkg::TPS_MIN;
    end else if (cfg_data_i > tcst_pkg::TPS_MAX) begin
      tps_d = tcst_pkg::TPS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= tcst_pkg::TPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tps_q <= tps_d;
    end
  end

  // --------------------------------------------------------------------------
  // Request unpacking, flag reduction and length check
  // --------------------------------------------------------------------------
  logic [IW-1:0]                in_idx;
  logic                         in_dir;
  logic [tcst_pkg::LEN_W-1:0]   in_len;
  logic [tcst_pkg::HDR_W:0]     hdr_words;
  logic [tcst_pkg::HDR_W+2:0]   hdr_bytes;
  logic                         in_len_ok;
  tcst_pkg::flag_cls_e          in_cls;
  logic                         in_acc;

  assign in_idx    = s_axis_tdata_i[7:0];
  assign in_dir    = s_axis_tdata_i[8];
  assign in_len    = s_axis_tdata_i[28:13];
  assign hdr_words = {1'b0, s_axis_tdata_i[32:29]} + {1'b0, s_axis_tdata_i[36:33]};
  assign hdr_bytes = {hdr_words, 2'b00};
  assign in_len_ok = in_len >= {{(tcst_pkg::LEN_W-tcst_pkg::HDR_W-3){1'b0}}, hdr_bytes};

  // priority RST, SYN, FIN, ACK
  always_comb begin
    if (s_axis_tdata_i[9]) begin
      in_cls = tcst_pkg::CLS_RST;
    end else if (s_axis_tdata_i[10]) begin
      in_cls = tcst_pkg::CLS_SYN;
    end else if (s_axis_tdata_i[11]) begin
      in_cls = tcst_pkg::CLS_FIN;
    end else if (s_axis_tdata_i[12]) begin
      in_cls = tcst_pkg::CLS_ACK;
    end else begin
      in_cls = tcst_pkg::CLS_NONE;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register (request held while the entry is read)
  // --------------------------------------------------------------------------
  logic                 s1_valid_q;
  logic                 s1_adv;
  logic                 out_free;
  tcst_pkg::action_e    s1_action_q;
  logic [IW-1:0]        s1_idx_q;
  logic                 s1_dir_q;
  tcst_pkg::flag_cls_e  s1_cls_q;
  logic                 s1_len_ok_q;

  logic                 out_valid_q;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= tcst_pkg::action_e'(s_axis_tuser_i);
      s1_idx_q    <= in_idx;
      s1_dir_q    <= in_dir;
      s1_cls_q    <= in_cls;
      s1_len_ok_q <= in_len_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Connection table: one write and one registered read per cycle.
  // Valid flops make never-written entries read as none / mark clear.
  // --------------------------------------------------------------------------
  tcst_pkg::entry_t     entry_mem [tcst_pkg::CONNECTIONS];
  logic [tcst_pkg::CONNECTIONS-1:0] vld_q;
  tcst_pkg::entry_t     rd_data_q;
  logic                 rd_vld_q;
  logic                 fwd_hit_q;
  tcst_pkg::entry_t     fwd_data_q;

  logic                 wr_req;
  logic                 wr_en;
  tcst_pkg::entry_t     wr_data;

  assign wr_en = wr_req && s1_adv;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[s1_idx_q] <= wr_data;
    end
    if (in_acc) begin
      rd_data_q <= entry_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s1_idx_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= vld_q[in_idx];
      end
    end
  end

  // write landing on the same edge as the read of the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_q <= wr_en && (s1_idx_q == in_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Transition logic
  // --------------------------------------------------------------------------
  tcst_pkg::entry_t     old_entry;
  logic [3:0]           old_st;
  logic                 old_mark;
  logic [3:0]           new_st;
  logic                 new_mark;
  tcst_pkg::verdict_e   verdict;
  logic [tcst_pkg::SECS_W+tcst_pkg::TPS_W-1:0] tmo_prod;
  logic [tcst_pkg::TMO_W-1:0] tmo;

  always_comb begin
    if (fwd_hit_q) begin
      old_entry = fwd_data_q;
    end else if (rd_vld_q) begin
      old_entry = rd_data_q;
    end else begin
      old_entry = '0;
    end
  end

  assign old_st   = (old_entry.st > tcst_pkg::ST_LAST) ? tcst_pkg::ST_NONE : old_entry.st;
  assign old_mark = old_entry.mark;

  always_comb begin
    wr_req   = 1'b0;
    new_st   = old_st;
    new_mark = old_mark;
    verdict  = tcst_pkg::VERDICT_INVALID;
    if (s1_action_q == tcst_pkg::ACT_OPEN) begin
      // open: original column from the none state, mark cleared
      wr_req   = 1'b1;
      new_mark = 1'b0;
      if (s1_cls_q == tcst_pkg::CLS_NONE) begin
        new_st = tcst_pkg::ST_NONE;
      end else begin
        new_st  = tcst_pkg::next_state_f(1'b0, s1_cls_q[1:0], tcst_pkg::ST_NONE);
        verdict = tcst_pkg::VERDICT_ACCEPT;
      end
    end else if (s1_len_ok_q && (s1_cls_q != tcst_pkg::CLS_NONE)) begin
      wr_req   = 1'b1;
      new_st   = tcst_pkg::next_state_f(s1_dir_q, s1_cls_q[1:0], old_st);
      new_mark = old_mark | s1_dir_q;
      // reset before any reply: delete straight away
      if (!old_mark && (s1_cls_q == tcst_pkg::CLS_RST)) begin
        verdict = tcst_pkg::VERDICT_DELETE;
      end else begin
        verdict = tcst_pkg::VERDICT_ACCEPT;
      end
    end
  end

  assign wr_data = {new_mark, new_st};

  assign tmo_prod = {{tcst_pkg::TPS_W{1'b0}}, tcst_pkg::state_seconds_f(new_st)} *
                    {{tcst_pkg::SECS_W{1'b0}}, tps_q};
  assign tmo      = (verdict == tcst_pkg::VERDICT_ACCEPT) ? tmo_prod[tcst_pkg::TMO_W-1:0] : '0;

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  tcst_pkg::verdict_e          out_verdict_q;
  logic [3:0]                  out_st_q;
  logic                        out_mark_q;
  logic [tcst_pkg::TMO_W-1:0]  out_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_verdict_q <= verdict;
      out_st_q      <= new_st;
      out_mark_q    <= new_mark;
      out_tmo_q     <= tmo;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_tmo_q, out_mark_q, out_st_q, out_verdict_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPL(a_tmo_zero, out_valid_q && (out_verdict_q != tcst_pkg::VERDICT_ACCEPT), out_tmo_q == '0)
  `ASSERT_IMPL(a_st_range, out_valid_q, out_st_q <= tcst_pkg::ST_LAST)
  `ASSERT_CLK(a_acc_fill, (s_axis_tvalid_i && s_axis_tready_o) |=> s1_valid_q)
  `ASSERT_CLK(a_fwd_src, (in_acc && wr_en && (s1_idx_q == in_idx)) |=> fwd_hit_q)

endmodule

`default_nettype wire
